@@ rtl/dtq_pkg.sv @@
package dtq_pkg;

  // Default sizes
  localparam int unsigned DEF_CAPACITY    = 32;
  localparam int unsigned DEF_TIME_BITS   = 48;
  localparam int unsigned DEF_HANDLE_BITS = 16;
  localparam int unsigned DEF_MAX_RETRY   = 1024;

  // Fixed field widths
  localparam int unsigned DELAY_BITS  = 32;
  localparam int unsigned SEQ_BITS    = 10;  // bump sequence runs modulo 1024
  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned STATUS_BITS = 2;

  // Request actions
  localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_TICK   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_FLUSH  = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STAT_RETRY = 2'd2;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

endpackage

@@ rtl/deadline_timer_queue.sv @@
// Insert: accept, a duplicate scan over the n held entries (cut short and restarted after
//   each collision bump), a shift walking back from the tail into place, then the status;
//   a full store goes from the accept, and a scan out of retries, straight to the status.
// Tick/flush: accept and setup, then one fired entry per cycle while the output accepts results.
// One request in flight at a time; s_axis_tready is high only when the sequencer is idle.
// Reset (rst_ni low, async) empties the queue and zeroes the bump sequence; memory not cleared.
module deadline_timer_queue #(
  parameter int unsigned CAPACITY    = dtq_pkg::DEF_CAPACITY,
  parameter int unsigned TIME_BITS   = dtq_pkg::DEF_TIME_BITS,
  parameter int unsigned HANDLE_BITS = dtq_pkg::DEF_HANDLE_BITS,
  parameter int unsigned MAX_RETRY   = dtq_pkg::DEF_MAX_RETRY,
  // derived widths
  parameter int unsigned IN_W  = ((TIME_BITS + dtq_pkg::DELAY_BITS + HANDLE_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W = ((HANDLE_BITS + TIME_BITS + dtq_pkg::STATUS_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_W-1:0]                    s_axis_tdata,  // now_time, delay_us, handle
  input  logic [dtq_pkg::ACTION_BITS-1:0]    s_axis_tuser,  // action
  // result channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata,  // fired_handle, deadline, status
  output logic                               m_axis_tuser,  // kind
  output logic                               m_axis_tlast   // last result of the request
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // memory address
  localparam int unsigned CW = $clog2(CAPACITY + 1);                     // 0..CAPACITY
  localparam int unsigned RW = $clog2(MAX_RETRY + 1);
  localparam logic [CW:0]   CAP_W   = (CW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [RW-1:0] RETRY_LIMIT = RW'(MAX_RETRY);

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a request
    ST_SCAN,    // duplicate deadline scan
    ST_SHIFT,   // walk back from the tail, opening a slot
    ST_EXPIRE,  // emit due entries from the head
    ST_RESP     // present the insert status
  } state_e;

  // Head-relative index to physical slot of the ring
  function automatic logic [AW-1:0] wrap_addr(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= CAP_W) s = s - CAP_W;
    return s[AW-1:0];
  endfunction

  // Request fields
  logic [TIME_BITS-1:0]            in_now;
  logic [dtq_pkg::DELAY_BITS-1:0]  in_delay;
  logic [HANDLE_BITS-1:0]          in_handle;
  assign in_now    = s_axis_tdata[TIME_BITS-1:0];
  assign in_delay  = s_axis_tdata[TIME_BITS +: dtq_pkg::DELAY_BITS];
  assign in_handle = s_axis_tdata[TIME_BITS + dtq_pkg::DELAY_BITS +: HANDLE_BITS];

  state_e                        state_q, state_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [dtq_pkg::SEQ_BITS-1:0]  bump_q, bump_d;
  logic [RW-1:0]                 retry_q, retry_d;
  logic [CW-1:0]                 idx_q, idx_d;
  logic                          all_q, all_d;      // flush: every entry is due
  logic [TIME_BITS-1:0]          now_q, now_d;
  logic [TIME_BITS-1:0]          dl_q, dl_d;        // deadline being inserted
  logic [HANDLE_BITS-1:0]        hd_q, hd_d;
  logic [dtq_pkg::STATUS_BITS-1:0] stat_q, stat_d;
  logic                          pend_vld_q, pend_vld_d;  // fired entry held for last flag
  logic [TIME_BITS-1:0]          pend_dl_q, pend_dl_d;
  logic [HANDLE_BITS-1:0]        pend_hd_q, pend_hd_d;
  logic                          out_vld_q, out_vld_d;
  logic [OUT_W-1:0]              out_data_q, out_data_d;
  logic                          out_kind_q, out_kind_d;
  logic                          out_last_q, out_last_d;

  // Entry memory, one write and one registered read port
  logic [TIME_BITS-1:0]   dl_mem [CAPACITY];
  logic [HANDLE_BITS-1:0] hd_mem [CAPACITY];
  logic [TIME_BITS-1:0]   rd_dl_q;
  logic [HANDLE_BITS-1:0] rd_hd_q;
  logic [CW-1:0]          rd_idx;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [TIME_BITS-1:0]   wr_dl;
  logic [HANDLE_BITS-1:0] wr_hd;

  // Shared deadline adder: now + delay on accept, deadline + bump on collision
  logic [TIME_BITS-1:0] add_a, add_b, add_sum;
  assign add_a   = (state_q == ST_IDLE) ? in_now : dl_q;
  assign add_b   = (state_q == ST_IDLE) ? TIME_BITS'(in_delay) : TIME_BITS'(bump_q);
  assign add_sum = add_a + add_b;

  logic out_free;
  logic due;
  assign out_free = !out_vld_q || m_axis_tready;
  assign due      = (idx_q != count_q) && (all_q || (rd_dl_q <= now_q));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    head_d     = head_q;
    bump_d     = bump_q;
    retry_d    = retry_q;
    idx_d      = idx_q;
    all_d      = all_q;
    now_d      = now_q;
    dl_d       = dl_q;
    hd_d       = hd_q;
    stat_d     = stat_q;
    pend_vld_d = pend_vld_q;
    pend_dl_d  = pend_dl_q;
    pend_hd_d  = pend_hd_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    wr_en      = 1'b0;
    wr_addr    = wrap_addr(head_q, idx_q);
    wr_dl      = dl_q;
    wr_hd      = hd_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          now_d = in_now;
          hd_d  = in_handle;
          idx_d = '0;
          case (s_axis_tuser)
            dtq_pkg::ACT_INSERT: begin
              dl_d    = add_sum;
              retry_d = '0;
              if (count_q == CAP_CNT) begin
                stat_d  = dtq_pkg::STAT_FULL;
                state_d = ST_RESP;
              end else begin
                stat_d  = dtq_pkg::STAT_OK;
                state_d = ST_SCAN;
              end
            end
            dtq_pkg::ACT_TICK, dtq_pkg::ACT_FLUSH: begin
              all_d      = (s_axis_tuser == dtq_pkg::ACT_FLUSH);
              pend_vld_d = 1'b0;
              state_d    = ST_EXPIRE;
            end
            default: ;  // unused code, dropped
          endcase
        end
      end

      ST_SCAN: begin
        // rd_dl_q holds entry idx_q
        if (idx_q == count_q) begin
          state_d = ST_SHIFT;
        end else if (rd_dl_q == dl_q) begin
          if (retry_q == RETRY_LIMIT) begin
            stat_d  = dtq_pkg::STAT_RETRY;
            state_d = ST_RESP;
          end else begin
            dl_d    = add_sum;
            bump_d  = bump_q + 1'b1;
            retry_d = retry_q + 1'b1;
            idx_d   = '0;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_SHIFT: begin
        // idx_q is the open slot, rd_dl_q holds the entry just below it
        wr_en = 1'b1;
        if ((idx_q != '0) && (rd_dl_q > dl_q)) begin
          wr_dl = rd_dl_q;
          wr_hd = rd_hd_q;
          idx_d = idx_q - 1'b1;
        end else begin
          count_d = count_q + 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_EXPIRE: begin
        if (!pend_vld_q) begin
          if (due) begin
            pend_vld_d = 1'b1;
            pend_dl_d  = rd_dl_q;
            pend_hd_d  = rd_hd_q;
            idx_d      = idx_q + 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = dtq_pkg::KIND_FIRED;
          out_last_d = !due;
          out_data_d = OUT_W'({dtq_pkg::STAT_OK, pend_dl_q, pend_hd_q});
          if (due) begin
            pend_dl_d = rd_dl_q;
            pend_hd_d = rd_hd_q;
            idx_d     = idx_q + 1'b1;
          end else begin
            // entries 0 .. idx_q-1 are gone
            pend_vld_d = 1'b0;
            head_d     = wrap_addr(head_q, idx_q);
            count_d    = count_q - idx_q;
            state_d    = ST_IDLE;
          end
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = dtq_pkg::KIND_STATUS;
          out_last_d = 1'b1;
          out_data_d = OUT_W'({stat_q, dl_q, hd_q});
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Read one entry ahead: the data for idx_d (the entry below it while shifting) is in rd_*_q next cycle
  always_comb begin
    if (state_d == ST_SHIFT) begin
      rd_idx = (idx_d == '0) ? '0 : idx_d - 1'b1;
    end else begin
      rd_idx = idx_d;
    end
  end
  assign rd_addr = wrap_addr(head_q, rd_idx);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dl_mem[wr_addr] <= wr_dl;
      hd_mem[wr_addr] <= wr_hd;
    end
    rd_dl_q <= dl_mem[rd_addr];
    rd_hd_q <= hd_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      head_q     <= '0;
      bump_q     <= '0;
      retry_q    <= '0;
      idx_q      <= '0;
      all_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      head_q     <= head_d;
      bump_q     <= bump_d;
      retry_q    <= retry_d;
      idx_q      <= idx_d;
      all_q      <= all_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      now_q      <= now_d;
      dl_q       <= dl_d;
      hd_q       <= hd_d;
      stat_q     <= stat_d;
      pend_dl_q  <= pend_dl_d;
      pend_hd_q  <= pend_hd_d;
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/dtq_checker.sv @@
module dtq_checker #(
  parameter int unsigned TIME_BITS   = dtq_pkg::DEF_TIME_BITS,
  parameter int unsigned HANDLE_BITS = dtq_pkg::DEF_HANDLE_BITS,
  parameter int unsigned OUT_W       = 72
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [dtq_pkg::ACTION_BITS-1:0] s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [OUT_W-1:0]                m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  logic [dtq_pkg::STATUS_BITS-1:0] m_status;
  assign m_status = m_axis_tdata[HANDLE_BITS + TIME_BITS +: dtq_pkg::STATUS_BITS];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Fired timers always carry status ok
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dtq_pkg::KIND_FIRED) |-> m_status == dtq_pkg::STAT_OK)
    else $error("fired timer with nonzero status");

  // An insert gives exactly one result, so it is always last
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == dtq_pkg::KIND_STATUS) |-> m_axis_tlast)
    else $error("insert status without last");

  // Ready drops once an insert request is accepted
  a_insert_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == dtq_pkg::ACT_INSERT)
      |=> !s_axis_tready)
    else $error("ready right after insert request");

endmodule

bind deadline_timer_queue dtq_checker #(
  .TIME_BITS   (TIME_BITS),
  .HANDLE_BITS (HANDLE_BITS),
  .OUT_W       (OUT_W)
) u_dtq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
